// ===== sv/qlt_pkg.sv =====
// ----------------------------------------------------------------------------
// qlt_pkg
// Shared types, character codes and helpers of the quoted line tokenizer.
// ----------------------------------------------------------------------------
package qlt_pkg;

    // Token limit as configured and as the 4-bit index / 5-bit count fields allow.
    localparam int         QLT_TOKEN_LIMIT = 16;
    localparam logic [4:0] QLT_LIMIT_EFF   =
        (QLT_TOKEN_LIMIT > 16) ? 5'd16 : 5'(QLT_TOKEN_LIMIT);

    // Most results one item can cause.
    localparam int QLT_MAX_RES = 3;
    localparam int QLT_RES_W   = $clog2(QLT_MAX_RES + 1);
    localparam int QLT_POS_W   = $clog2(QLT_MAX_RES);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UC_X   = 8'h58;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_CASE   = 8'h20;

    typedef enum logic [1:0] {
        OK_BYTE         = 2'd0,
        OK_TOKEN_CLOSED = 2'd1,
        OK_LINE_CLOSED  = 2'd2
    } t_out_kind;

    typedef enum logic [8:0] {
        M_SKIPWS    = 9'b000000001,
        M_TOKEN     = 9'b000000010,
        M_QUOTED    = 9'b000000100,
        M_ESC       = 9'b000001000,
        M_HEX1      = 9'b000010000,
        M_HEX2      = 9'b000100000,
        M_SLASH_WS  = 9'b001000000,
        M_SLASH_TOK = 9'b010000000,
        M_DONE      = 9'b100000000
    } t_scan_mode;

    typedef struct packed {
        t_out_kind  kind;
        logic [7:0] data;
    } t_res_ent;

    // All results of one item, with the token count they report.
    typedef struct packed {
        logic [QLT_RES_W-1:0]           cnt;
        logic [4:0]                     count;
        t_res_ent [QLT_MAX_RES-1:0]     ent;
    } t_bundle;

    function automatic logic is_hex(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | CH_CASE;
        return ((c >= CH_ZERO) && (c <= CH_NINE)) || ((lc >= CH_LC_A) && (lc <= CH_LC_F));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] lc;
        logic [7:0] v;
        lc = c | CH_CASE;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            v = c - CH_ZERO;
        end else begin
            v = lc - CH_LC_A + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

// ===== sv/qlt_parser.sv =====
// ----------------------------------------------------------------------------
// qlt_parser
// Input register, scan state and the one-pass step that turns a registered
// byte or end-of-line item into a bundle of up to three results.
// ----------------------------------------------------------------------------
module qlt_parser
    import qlt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_line_byte,
    input  logic       i_take,
    output logic       o_load,
    output t_bundle    o_bundle
);

    logic       r_in_valid;
    logic       r_in_kind;
    logic [7:0] r_in_byte;

    t_scan_mode r_mode, n_mode;
    logic       r_qs, n_qs;
    logic [7:0] r_hex, n_hex;
    logic [4:0] r_tok, n_tok;

    logic       consume;
    logic [7:0] c;
    logic       is_ws, is_nul, is_hash, is_slash, is_quote, is_bs, is_endq;
    logic       tb_close, tb_byte, qb_close, qb_byte;
    t_scan_mode tb_mode, qb_mode;
    logic       at_limit;
    t_bundle    bd;

    function automatic t_bundle put(input t_bundle b, input t_out_kind k,
                                    input logic [7:0] d);
        t_bundle r;
        r = b;
        r.ent[r.cnt[QLT_POS_W-1:0]].kind = k;
        r.ent[r.cnt[QLT_POS_W-1:0]].data = (k == OK_BYTE) ? d : 8'h00;
        r.cnt = r.cnt + 1'b1;
        return r;
    endfunction

    // Closes the token, passes the byte on, or does neither, as one plain byte does.
    function automatic t_bundle put_step(input t_bundle b, input logic cl,
                                         input logic by, input logic [7:0] d);
        t_bundle r;
        r = b;
        if (cl) begin
            r = put(r, OK_TOKEN_CLOSED, 8'h00);
        end else if (by) begin
            r = put(r, OK_BYTE, d);
        end
        return r;
    endfunction

    assign consume    = r_in_valid && i_take;
    assign o_in_stall = r_in_valid && !i_take;
    assign o_load     = consume;
    assign o_bundle   = bd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_line_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_SKIPWS;
            r_qs   <= 1'b0;
            r_hex  <= 8'h00;
            r_tok  <= 5'd0;
        end else if (consume) begin
            r_mode <= n_mode;
            r_qs   <= n_qs;
            r_hex  <= n_hex;
            r_tok  <= n_tok;
        end
    end

    // End of line is parsed as a NUL byte first.
    assign c        = r_in_kind ? CH_NUL : r_in_byte;
    assign is_ws    = (c == CH_SPACE) || (c == CH_TAB);
    assign is_nul   = (c == CH_NUL);
    assign is_hash  = (c == CH_HASH);
    assign is_slash = (c == CH_SLASH);
    assign is_quote = (c == CH_DQUOTE) || (c == CH_SQUOTE);
    assign is_bs    = (c == CH_BSLASH);
    assign is_endq  = (c == (r_qs ? CH_SQUOTE : CH_DQUOTE));
    assign at_limit = (r_tok >= QLT_LIMIT_EFF);

    assign tb_close = is_nul || is_hash || is_ws;
    assign tb_byte  = !(tb_close || is_slash);
    assign qb_close = is_nul || is_endq;
    assign qb_byte  = !(qb_close || is_bs);

    always_comb begin
        priority if (is_nul || is_hash) begin
            tb_mode = M_DONE;
        end else if (is_ws) begin
            tb_mode = M_SKIPWS;
        end else if (is_slash) begin
            tb_mode = M_SLASH_TOK;
        end else begin
            tb_mode = M_TOKEN;
        end
        priority if (is_nul) begin
            qb_mode = M_DONE;
        end else if (is_endq) begin
            qb_mode = M_SKIPWS;
        end else if (is_bs) begin
            qb_mode = M_ESC;
        end else begin
            qb_mode = M_QUOTED;
        end
    end

    always_comb begin
        bd     = '0;
        n_mode = r_mode;
        n_qs   = r_qs;
        n_hex  = r_hex;
        n_tok  = r_tok;
        unique case (r_mode)
            M_SKIPWS: begin
                priority if (is_ws) begin
                    n_mode = M_SKIPWS;
                end else if (is_nul || is_hash) begin
                    n_mode = M_DONE;
                end else if (is_slash) begin
                    n_mode = M_SLASH_WS;
                end else if (at_limit) begin
                    n_mode = M_DONE;
                end else begin
                    n_tok = r_tok + 5'd1;
                    if (is_quote) begin
                        n_qs   = (c == CH_SQUOTE);
                        n_mode = M_QUOTED;
                    end else begin
                        n_mode = M_TOKEN;
                        bd     = put(bd, OK_BYTE, c);
                    end
                end
            end
            M_TOKEN: begin
                n_mode = tb_mode;
                bd     = put_step(bd, tb_close, tb_byte, c);
            end
            M_QUOTED: begin
                n_mode = qb_mode;
                bd     = put_step(bd, qb_close, qb_byte, c);
            end
            M_ESC: begin
                n_mode = M_QUOTED;
                priority if (c == CH_LC_N) begin
                    bd = put(bd, OK_BYTE, CH_LF);
                end else if (c == CH_LC_R) begin
                    bd = put(bd, OK_BYTE, CH_CR);
                end else if (c == CH_LC_T) begin
                    bd = put(bd, OK_BYTE, CH_TAB);
                end else if ((c == CH_LC_X) || (c == CH_UC_X)) begin
                    n_mode = M_HEX1;
                end else if (is_nul) begin
                    n_mode = M_DONE;
                    bd     = put(bd, OK_TOKEN_CLOSED, 8'h00);
                end else begin
                    bd = put(bd, OK_BYTE, c);
                end
            end
            M_HEX1: begin
                if (is_hex(c)) begin
                    n_hex  = c;
                    n_mode = M_HEX2;
                end else begin
                    n_mode = qb_mode;
                    bd     = put_step(bd, qb_close, qb_byte, c);
                end
            end
            M_HEX2: begin
                n_hex = 8'h00;
                if (is_hex(c)) begin
                    n_mode = M_QUOTED;
                    bd     = put(bd, OK_BYTE, {hex_val(r_hex), hex_val(c)});
                end else begin
                    // A malformed escape keeps the held digit as a plain byte.
                    n_mode = qb_mode;
                    bd     = put(bd, OK_BYTE, r_hex);
                    bd     = put_step(bd, qb_close, qb_byte, c);
                end
            end
            M_SLASH_WS: begin
                if (is_slash || at_limit) begin
                    n_mode = M_DONE;
                end else begin
                    n_tok  = r_tok + 5'd1;
                    n_mode = tb_mode;
                    bd     = put(bd, OK_BYTE, CH_SLASH);
                    bd     = put_step(bd, tb_close, tb_byte, c);
                end
            end
            M_SLASH_TOK: begin
                if (is_slash) begin
                    n_mode = M_DONE;
                    bd     = put(bd, OK_TOKEN_CLOSED, 8'h00);
                end else begin
                    n_mode = tb_mode;
                    bd     = put(bd, OK_BYTE, CH_SLASH);
                    bd     = put_step(bd, tb_close, tb_byte, c);
                end
            end
            M_DONE: begin
                n_mode = M_DONE;
            end
            default: begin
                n_mode = M_DONE;
            end
        endcase
        bd.count = n_tok;
        if (r_in_kind) begin
            bd     = put(bd, OK_LINE_CLOSED, 8'h00);
            n_mode = M_SKIPWS;
            n_qs   = 1'b0;
            n_hex  = 8'h00;
            n_tok  = 5'd0;
        end
    end

endmodule

// ===== sv/qlt_emitter.sv =====
// ----------------------------------------------------------------------------
// qlt_emitter
// Result register holding one item's bundle and handing its results out one
// word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module qlt_emitter
    import qlt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_bundle    i_bundle,
    output logic       o_take,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_byte,
    output logic [3:0] o_token_index,
    output logic [4:0] o_token_count,
    output logic       o_last
);

    logic [QLT_RES_W-1:0]       r_cnt;
    logic [QLT_POS_W-1:0]       r_pos;
    logic [4:0]                 r_count;
    t_res_ent [QLT_MAX_RES-1:0] r_ent;

    t_res_ent cur;
    logic     done;

    assign cur         = r_ent[r_pos];
    assign o_out_valid = (r_cnt != '0);
    assign o_last      = (r_pos == QLT_POS_W'(r_cnt - 1'b1));
    assign done        = o_out_valid && !i_out_stall && o_last;
    assign o_take      = !o_out_valid || done;

    assign o_out_kind    = cur.kind;
    assign o_out_byte    = cur.data;
    assign o_token_count = r_count;
    assign o_token_index = ((cur.kind == OK_LINE_CLOSED) || (r_count == 5'd0))
                           ? 4'd0 : 4'(r_count - 5'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pos <= '0;
        end else if (i_load) begin
            r_cnt <= i_bundle.cnt;
            r_pos <= '0;
        end else if (o_out_valid && !i_out_stall) begin
            if (o_last) begin
                r_cnt <= '0;
            end else begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent   <= i_bundle.ent;
            r_count <= i_bundle.count;
        end
    end

endmodule

// ===== sv/quoted_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// quoted_line_tokenizer
// Splits a text line, fed one byte per word and closed by an end-of-line
// word, into tokens with quoting, escapes and comments.
// ----------------------------------------------------------------------------
// A byte word passes an input register, is parsed combinationally and its
// results (at most three: two for a byte, three for end of line) land in a
// result register, from which they leave one word per cycle while the output
// is not stalled. The block takes one input word per cycle as long as each
// word causes at most one result and the output is not stalled; a word with
// more results holds the input until the result register, with its single
// output port, has handed them all out. Words that cause no result
// (whitespace, a pending slash or hex digit, anything after a comment)
// produce nothing. End of line closes the open token, reports line closed
// with the token count, and clears all state for the next line.
module quoted_line_tokenizer
    import qlt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_line_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_byte,
    output logic [3:0] o_token_index,
    output logic [4:0] o_token_count,
    output logic       o_last
);

    logic    take;
    logic    load;
    t_bundle bundle;

    qlt_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_line_byte (i_line_byte),
        .i_take      (take),
        .o_load      (load),
        .o_bundle    (bundle)
    );

    qlt_emitter u_emitter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_bundle      (bundle),
        .o_take        (take),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_kind    (o_out_kind),
        .o_out_byte    (o_out_byte),
        .o_token_index (o_token_index),
        .o_token_count (o_token_count),
        .o_last        (o_last)
    );

endmodule

// ===== sv/qlt_checker.sv =====
// ----------------------------------------------------------------------------
// qlt_checker
// Port-level checks of the tokenizer, bound to its top level.
// ----------------------------------------------------------------------------
module qlt_checker
    import qlt_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_kind,
    input logic [7:0] i_line_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_out_kind,
    input logic [7:0] o_out_byte,
    input logic [3:0] o_token_index,
    input logic [4:0] o_token_count,
    input logic       o_last
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_kind)
            && $stable(o_out_byte) && $stable(o_token_count) && $stable(o_last)))
        else $error("result word changed while stalled");

    // Token words belong to the most recently started token.
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_kind != OK_LINE_CLOSED)) |->
            ((o_token_count != 5'd0) && (o_token_index == 4'(o_token_count - 5'd1))))
        else $error("token index does not match token count");

    // Line closed is always the final result of its word.
    a_line_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_kind == OK_LINE_CLOSED)) |->
            (o_last && (o_token_index == 4'd0) && (o_out_byte == 8'h00)))
        else $error("malformed line closed word");

    // Kind stays in range and the count never passes the limit.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_kind != 2'd3) && (o_token_count <= QLT_LIMIT_EFF)))
        else $error("result kind or token count out of range");

endmodule

bind quoted_line_tokenizer qlt_checker u_qlt_checker (.*);
